FILE: design/gvs_pkg.sv
`default_nettype none

package gvs_pkg;

    // fixed field widths
    localparam int CNT_W   = 7;
    localparam int BLOCK_W = 10;
    localparam int ERASE_W = 16;

    // default sizing
    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int MAX_PAGES      = 64;

    // reset value of the pages-per-block register, clipped to the field
    localparam logic [CNT_W-1:0] PPB_RESET =
        (MAX_PAGES > 127) ? CNT_W'(127) : CNT_W'(MAX_PAGES);

    localparam logic [ERASE_W-1:0] ERASE_MAX = '1;

    // action codes
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COLLECT = 1'b1;

    // controller states
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_LOOKUP = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

FILE: design/gvs_cmd_if.sv
`default_nettype none

interface gvs_cmd_if
    import gvs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               action;
    logic [BLOCK_W-1:0] block_index;
    logic [CNT_W-1:0]   valid_pages;
    logic [CNT_W-1:0]   free_pages;

    modport source (
        output valid,
        output action,
        output block_index,
        output valid_pages,
        output free_pages,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  block_index,
        input  valid_pages,
        input  free_pages,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/gvs_result_if.sv
`default_nettype none

interface gvs_result_if
    import gvs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               found;
    logic [BLOCK_W-1:0] victim_block;
    logic [CNT_W-1:0]   victim_valid;
    logic [ERASE_W-1:0] victim_erase_count;

    modport source (
        output valid,
        output found,
        output victim_block,
        output victim_valid,
        output victim_erase_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  victim_block,
        input  victim_valid,
        input  victim_erase_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/gvs_ram.sv
`default_nettype none

module gvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/gvs_scan.sv
`default_nettype none

module gvs_scan
    import gvs_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          sample,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0] idx,
    input  wire logic [CNT_W-1:0]              valid_cnt,
    input  wire logic [CNT_W-1:0]              free_cnt,
    input  wire logic [CNT_W-1:0]              ppb,
    output logic                               have,
    output logic [$clog2(NUM_BLOCKS)-1:0]      best,
    output logic [CNT_W-1:0]                   best_valid
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    logic             have_reg;
    logic [IDX_W-1:0] best_reg;
    logic [CNT_W-1:0] best_valid_reg;
    logic             take;

    // entry qualifies unless wholly free; strict compare keeps lowest index on ties
    assign take = sample && (free_cnt != ppb) && (!have_reg || (valid_cnt < best_valid_reg));

    // running minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (start)
        begin
            have_reg <= 1'b0;
        end
        else if (take)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !start)
        begin
            best_reg       <= idx;
            best_valid_reg <= valid_cnt;
        end
    end

    assign have       = have_reg;
    assign best       = best_reg;
    assign best_valid = best_valid_reg;

endmodule

`default_nettype wire

FILE: design/greedy_gc_victim_select_core.sv
`default_nettype none

// greedy garbage-collection victim selection for one flash chip
// cmd channel (valid/ready): action 0 writes the valid and free page counts
// of one block (no result); action 1 scans every block for the lowest valid
// count among blocks that are not wholly free, lowest index on ties.
// result channel (valid/ready): one transaction per collect: found flag,
// victim index, its valid count and its erase count after the increment.
// the victim's free count becomes pages_per_block minus its valid count (zero if negative).
// cfg_we/cfg_wdata write pages_per_block; write it only while idle.
// a write item completes on acceptance. a collect has the scan read one
// entry per cycle from the counts memory, then drains, looks up the victim,
// updates it if one is found and finishes; cmd.ready returns in the same
// cycle that the result appears.
// after reset a clearing pass initializes the tables;
// cmd.ready stays low meanwhile.
// the result sits in an output register; a new cmd transaction is taken
// while it waits. a later collect holds before delivery until the result
// register is free.

module greedy_gc_victim_select_core
    import gvs_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    gvs_cmd_if.sink               cmd,
    gvs_result_if.source          result
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNTS_W = 2 * CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]   ppb_reg;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic               res_found_reg;
    logic [BLOCK_W-1:0] res_block_reg;
    logic [CNT_W-1:0]   res_valid_reg;
    logic [ERASE_W-1:0] res_erase_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [BLOCK_W-1:0] out_block_reg;
    logic [CNT_W-1:0]   out_valid_cnt_reg;
    logic [ERASE_W-1:0] out_erase_reg;

    logic               cmd_fire;
    logic               wr_in_range;
    logic               out_free;

    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_waddr;
    logic [CNTS_W-1:0]  cnt_wdata;
    logic [CNTS_W-1:0]  cnt_rdata;

    logic               ers_we;
    logic [ERASE_W-1:0] ers_wdata;
    logic [ERASE_W-1:0] ers_rdata;

    logic               have;
    logic [IDX_W-1:0]   best;
    logic [CNT_W-1:0]   best_valid;

    logic [CNT_W-1:0]   new_free;
    logic [ERASE_W-1:0] new_erase;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign wr_in_range = (32'(cmd.block_index) < 32'(NUM_BLOCKS));
    assign out_free    = !out_valid_reg || result.ready;

    // reclaim arithmetic
    assign new_free  = (best_valid > ppb_reg) ? '0 : CNT_W'(ppb_reg - best_valid);
    assign new_erase = (ers_rdata == ERASE_MAX) ? ers_rdata : ERASE_W'(ers_rdata + 1'b1);

    // counts memory: {free, valid} per block
    gvs_ram #(
        .WIDTH (CNTS_W),
        .DEPTH (NUM_BLOCKS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (scan_addr_reg),
        .rdata (cnt_rdata)
    );

    // erase count memory
    gvs_ram #(
        .WIDTH (ERASE_W),
        .DEPTH (NUM_BLOCKS)
    ) u_ers_ram (
        .clk   (clk),
        .we    (ers_we),
        .waddr ((state_reg == ST_CLEAR) ? clr_addr_reg : best),
        .wdata (ers_wdata),
        .raddr (best),
        .rdata (ers_rdata)
    );

    // minimum search over the streamed entries
    gvs_scan #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd_fire && (cmd.action == ACT_COLLECT)),
        .sample     (rd_valid_reg),
        .idx        (rd_idx_reg),
        .valid_cnt  (cnt_rdata[CNT_W-1:0]),
        .free_cnt   (cnt_rdata[CNTS_W-1:CNT_W]),
        .ppb        (ppb_reg),
        .have       (have),
        .best       (best),
        .best_valid (best_valid)
    );

    // memory write selection
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = clr_addr_reg;
        cnt_wdata = {PPB_RESET, CNT_W'(0)};
        ers_we    = 1'b0;
        ers_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we = 1'b1;
                ers_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.action == ACT_WRITE) && wr_in_range)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = IDX_W'(cmd.block_index);
                    cnt_wdata = {cmd.free_pages, cmd.valid_pages};
                end
            end
            ST_UPDATE:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = best;
                cnt_wdata = {new_free, best_valid};
                ers_we    = 1'b1;
                ers_wdata = new_erase;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.action == ACT_COLLECT))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = have ? ST_UPDATE : ST_FINISH;
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ppb_reg       <= PPB_RESET;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                ppb_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= IDX_W'(clr_addr_reg + 1'b1);
            end
            // scan address walks the table once per collect
            if (state_reg == ST_SCAN)
            begin
                scan_addr_reg <= IDX_W'(scan_addr_reg + 1'b1);
            end
            else
            begin
                scan_addr_reg <= '0;
            end
            rd_valid_reg <= (state_reg == ST_SCAN);
            // output register
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_addr_reg;
        if (state_reg == ST_LOOKUP)
        begin
            res_found_reg <= 1'b0;
            res_block_reg <= '0;
            res_valid_reg <= '0;
            res_erase_reg <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            res_found_reg <= 1'b1;
            res_block_reg <= BLOCK_W'(best);
            res_valid_reg <= best_valid;
            res_erase_reg <= new_erase;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_found_reg     <= res_found_reg;
            out_block_reg     <= res_block_reg;
            out_valid_cnt_reg <= res_valid_reg;
            out_erase_reg     <= res_erase_reg;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.found              = out_found_reg;
    assign result.victim_block       = out_block_reg;
    assign result.victim_valid       = out_valid_cnt_reg;
    assign result.victim_erase_count = out_erase_reg;

endmodule

`default_nettype wire
